// File: rtl/core/rc4d_pkg.sv
// Shared types and constants for the RC4-drop stream cipher core.
// No dependencies; imported by every module of the core but rc4d_ram.

package rc4d_pkg;

    // S-box geometry
    localparam int STATE_SIZE = 256;
    localparam int IDX_W      = $clog2(STATE_SIZE);
    localparam int BYTE_W     = 8;

    // Configuration register widths
    localparam int DROP_W     = 8;
    localparam int KLEN_W     = 9;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int DROP_CNT_W = DROP_W + IDX_W;

    // Largest usable key length
    localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(STATE_SIZE);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(STATE_SIZE - 1);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 1'b1;

    // Request kinds on tuser
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Configuration as seen by the engine
    typedef struct packed {
        logic [DROP_W-1:0] drop_blocks;
        logic [KLEN_W-1:0] key_length;
    } t_cfg;

    // One port set of a byte-wide memory
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } t_ram_req;

    // Result offered by the engine to the output register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              not_keyed;
    } t_res;

endpackage

// File: rtl/core/rc4d_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; width and depth come from parameters.

module rc4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rc4d_engine.sv
// Key load, key schedule, keystream drop and keystream generation sequencer.
// Depends on rc4d_pkg; drives the S-box and key memories held in the top level.

module rc4d_engine
    import rc4d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input request
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [BYTE_W-1:0] i_byte,
    // configuration
    input  t_cfg              i_cfg,
    // memories
    output t_ram_req          o_sbox_req,
    input  logic [BYTE_W-1:0] i_sbox_rdata,
    output t_ram_req          o_key_req,
    input  logic [BYTE_W-1:0] i_key_rdata,
    // result
    output t_res              o_res,
    input  logic              i_res_free
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_FILL = 10'b00_0000_0010,
        ST_KS1  = 10'b00_0000_0100,
        ST_KS2  = 10'b00_0000_1000,
        ST_KS3  = 10'b00_0001_0000,
        ST_KS4  = 10'b00_0010_0000,
        ST_PR1  = 10'b00_0100_0000,
        ST_PR2  = 10'b00_1000_0000,
        ST_PR3  = 10'b01_0000_0000,
        ST_PR4  = 10'b10_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_i, n_i;
    logic [IDX_W-1:0]      r_j, n_j;
    logic [IDX_W-1:0]      r_k, n_k;
    logic [KLEN_W-1:0]     r_len, n_len;
    logic [KLEN_W-1:0]     r_cnt, n_cnt;
    logic                  r_keyed, n_keyed;
    logic [DROP_CNT_W-1:0] r_drop_cnt, n_drop_cnt;
    logic [BYTE_W-1:0]     r_si, n_si;
    logic [BYTE_W-1:0]     r_byte, n_byte;
    logic                  r_pass, n_pass;
    logic                  r_drop, n_drop;
    logic                  r_fwd_en, n_fwd_en;
    logic [BYTE_W-1:0]     r_fwd_val, n_fwd_val;

    logic              accept;
    logic [KLEN_W-1:0] eff_len;
    logic [KLEN_W-1:0] cnt_base;
    logic [KLEN_W-1:0] cnt_inc;
    logic [KLEN_W-1:0] k_inc;
    logic [IDX_W-1:0]  j_ksa;
    logic [IDX_W-1:0]  j_prga;
    logic [IDX_W-1:0]  t_addr;
    logic [BYTE_W-1:0] ks;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // Key length of zero or beyond the S-box size means a full-size key
    assign eff_len = ((i_cfg.key_length == '0) || (i_cfg.key_length > KLEN_MAX))
                     ? KLEN_MAX : i_cfg.key_length;

    // A key byte after keying restarts the load
    assign cnt_base = r_keyed ? '0 : r_cnt;
    assign cnt_inc  = cnt_base + KLEN_W'(1);
    assign k_inc    = {1'b0, r_k} + KLEN_W'(1);

    // Index arithmetic, all mod 256
    assign j_ksa  = r_j + i_sbox_rdata + i_key_rdata;
    assign j_prga = r_j + i_sbox_rdata;
    assign t_addr = r_si + i_sbox_rdata;

    // Keystream byte, with the swap forwarded past the read
    assign ks = r_fwd_en ? r_fwd_val : i_sbox_rdata;

    // Result request
    always_comb begin
        o_res.valid     = (r_state == ST_PR4) && !r_drop;
        o_res.data      = r_pass ? r_byte : (r_byte ^ ks);
        o_res.not_keyed = r_pass;
    end

    // Memory port control
    always_comb begin
        o_sbox_req = '0;
        o_key_req  = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_func == FUNC_DATA) && r_keyed) begin
                    o_sbox_req.rd_en   = 1'b1;
                    o_sbox_req.rd_addr = r_i + IDX_W'(1);
                end
                if (accept && (i_func == FUNC_KEY)) begin
                    o_key_req.wr_en   = 1'b1;
                    o_key_req.wr_addr = cnt_base[IDX_W-1:0];
                    o_key_req.wr_data = i_byte;
                end
            end
            ST_FILL: begin
                o_sbox_req.wr_en   = 1'b1;
                o_sbox_req.wr_addr = r_i;
                o_sbox_req.wr_data = BYTE_W'(r_i);
            end
            ST_KS1: begin
                o_sbox_req.rd_en   = 1'b1;
                o_sbox_req.rd_addr = r_i;
                o_key_req.rd_en    = 1'b1;
                o_key_req.rd_addr  = r_k;
            end
            ST_KS2: begin
                o_sbox_req.rd_en   = 1'b1;
                o_sbox_req.rd_addr = j_ksa;
            end
            ST_KS3: begin
                o_sbox_req.wr_en   = 1'b1;
                o_sbox_req.wr_addr = r_i;
                o_sbox_req.wr_data = i_sbox_rdata;
            end
            ST_KS4: begin
                o_sbox_req.wr_en   = 1'b1;
                o_sbox_req.wr_addr = r_j;
                o_sbox_req.wr_data = r_si;
            end
            ST_PR1: begin
                o_sbox_req.rd_en   = 1'b1;
                o_sbox_req.rd_addr = r_i + IDX_W'(1);
            end
            ST_PR2: begin
                o_sbox_req.rd_en   = 1'b1;
                o_sbox_req.rd_addr = j_prga;
            end
            ST_PR3: begin
                o_sbox_req.wr_en   = 1'b1;
                o_sbox_req.wr_addr = r_i;
                o_sbox_req.wr_data = i_sbox_rdata;
                o_sbox_req.rd_en   = 1'b1;
                o_sbox_req.rd_addr = t_addr;
            end
            ST_PR4: begin
                o_sbox_req.wr_en   = !r_pass;
                o_sbox_req.wr_addr = r_j;
                o_sbox_req.wr_data = r_si;
            end
            default: begin
                o_sbox_req = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_keyed    = r_keyed;
        n_drop_cnt = r_drop_cnt;
        n_si       = r_si;
        n_byte     = r_byte;
        n_pass     = r_pass;
        n_drop     = r_drop;
        n_fwd_en   = r_fwd_en;
        n_fwd_val  = r_fwd_val;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_func == FUNC_KEY)) begin
                    n_keyed = 1'b0;
                    n_cnt   = cnt_inc;
                    if (cnt_inc >= eff_len) begin
                        n_len   = eff_len;
                        n_cnt   = '0;
                        n_i     = '0;
                        n_state = ST_FILL;
                    end
                end else if (accept) begin
                    n_byte = i_byte;
                    n_drop = 1'b0;
                    if (r_keyed) begin
                        n_i     = r_i + IDX_W'(1);
                        n_pass  = 1'b0;
                        n_state = ST_PR2;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = ST_PR4;
                    end
                end
            end
            // S-box back to identity, one entry a cycle
            ST_FILL: begin
                n_i = r_i + IDX_W'(1);
                if (r_i == IDX_LAST) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_KS1;
                end
            end
            ST_KS1: begin
                n_state = ST_KS2;
            end
            ST_KS2: begin
                n_si    = i_sbox_rdata;
                n_j     = j_ksa;
                n_state = ST_KS3;
            end
            ST_KS3: begin
                n_state = ST_KS4;
            end
            // End of one schedule step: advance key index, wrap at key length
            ST_KS4: begin
                n_i     = r_i + IDX_W'(1);
                n_k     = (k_inc >= r_len) ? '0 : k_inc[IDX_W-1:0];
                n_state = ST_KS1;
                if (r_i == IDX_LAST) begin
                    n_i        = '0;
                    n_j        = '0;
                    n_drop_cnt = {i_cfg.drop_blocks, IDX_W'(0)};
                    if (i_cfg.drop_blocks == '0) begin
                        n_keyed = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_drop  = 1'b1;
                        n_pass  = 1'b0;
                        n_state = ST_PR1;
                    end
                end
            end
            ST_PR1: begin
                n_i     = r_i + IDX_W'(1);
                n_state = ST_PR2;
            end
            ST_PR2: begin
                n_si    = i_sbox_rdata;
                n_j     = j_prga;
                n_state = ST_PR3;
            end
            // After the swap S[i] holds old S[j] and S[j] holds old S[i]
            ST_PR3: begin
                n_fwd_en  = (t_addr == r_j) || (t_addr == r_i);
                n_fwd_val = (t_addr == r_j) ? r_si : i_sbox_rdata;
                n_state   = ST_PR4;
            end
            ST_PR4: begin
                if (r_drop) begin
                    n_drop_cnt = r_drop_cnt - DROP_CNT_W'(1);
                    if (r_drop_cnt == DROP_CNT_W'(1)) begin
                        n_keyed = 1'b1;
                        n_drop  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_PR1;
                    end
                end else if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_len      <= KLEN_MAX;
            r_cnt      <= '0;
            r_keyed    <= 1'b0;
            r_drop_cnt <= '0;
            r_pass     <= 1'b0;
            r_drop     <= 1'b0;
            r_fwd_en   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_len      <= n_len;
            r_cnt      <= n_cnt;
            r_keyed    <= n_keyed;
            r_drop_cnt <= n_drop_cnt;
            r_pass     <= n_pass;
            r_drop     <= n_drop;
            r_fwd_en   <= n_fwd_en;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_si      <= n_si;
        r_byte    <= n_byte;
        r_fwd_val <= n_fwd_val;
    end

endmodule

// File: rtl/core/rc4_drop_stream_cipher_core.sv
// RC4 with a 256*drop_blocks byte keystream drop. Data byte, keyed: the engine steps through
// PR2, PR3 and PR4 and the result enters the output register; tready returns once the result
// is taken by that register. Not keyed: PR4 only. A key byte leaves tready high, but the last
// one of a load holds tready low through the fill, the schedule and the drop. The keyed byte
// steps come from the dependent S-box reads and the swap through the one memory port pair.
// Synchronous active-low reset clears control state and configuration, not memories.

module rc4_drop_stream_cipher_core
    import rc4d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [BYTE_W-1:0]    i_s_axis_tdata,   // [7:0] byte_in
    input  logic                 i_s_axis_tuser,   // [0] func
    // output stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [BYTE_W-1:0]    o_m_axis_tdata,   // [7:0] byte_out
    output logic                 o_m_axis_tuser,   // [0] not_keyed
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg              r_cfg;
    t_ram_req          sbox_req;
    t_ram_req          key_req;
    logic [BYTE_W-1:0] sbox_rdata;
    logic [BYTE_W-1:0] key_rdata;
    t_res              res;
    logic              res_free;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_nk;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_blocks <= '0;
            r_cfg.key_length  <= KLEN_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DROP_BLOCKS: r_cfg.drop_blocks <= i_cfg_wdata[DROP_W-1:0];
                CFG_KEY_LENGTH:  r_cfg.key_length  <= i_cfg_wdata[KLEN_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    rc4d_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_func       (i_s_axis_tuser),
        .i_byte       (i_s_axis_tdata),
        .i_cfg        (r_cfg),
        .o_sbox_req   (sbox_req),
        .i_sbox_rdata (sbox_rdata),
        .o_key_req    (key_req),
        .i_key_rdata  (key_rdata),
        .o_res        (res),
        .i_res_free   (res_free)
    );

    // S-box permutation
    rc4d_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STATE_SIZE)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (sbox_req.wr_en),
        .i_waddr (sbox_req.wr_addr),
        .i_wdata (sbox_req.wr_data),
        .i_re    (sbox_req.rd_en),
        .i_raddr (sbox_req.rd_addr),
        .o_rdata (sbox_rdata)
    );

    // Key byte store
    rc4d_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STATE_SIZE)
    ) u_key (
        .i_clk   (i_clk),
        .i_we    (key_req.wr_en),
        .i_waddr (key_req.wr_addr),
        .i_wdata (key_req.wr_data),
        .i_re    (key_req.rd_en),
        .i_raddr (key_req.rd_addr),
        .o_rdata (key_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign res_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res.valid) begin
            r_out_data <= res.data;
            r_out_nk   <= res.not_keyed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_nk;

endmodule

// File: rtl/core/rc4d_checker.sv
// Port-level assertions for the RC4-drop core, attached by bind.
// Depends on rc4d_pkg and on the top level rc4_drop_stream_cipher_core.

module rc4d_checker
    import rc4d_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [BYTE_W-1:0]    o_m_axis_tdata,
    input logic                 o_m_axis_tuser
);

    logic s_acc;
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A data request leaves the engine busy in the cycle after it is taken
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_axis_tuser == FUNC_DATA)) |=> !o_s_axis_tready)
        else $error("request accepted right after a data request");

    // A new result never appears the cycle right after a request is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(s_acc))
        else $error("result appeared too early");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind rc4_drop_stream_cipher_core rc4d_checker u_rc4d_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: tb/rc4_drop_stream_cipher_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rc4_drop_stream_cipher_core: a directed table, then random key loads
// and data bursts, each checked against an RC4-drop keystream predictor. Needs rc4d_pkg.

module rc4_drop_stream_cipher_core_test
    import rc4d_pkg::*;
();

    localparam int ITEM_TARGET    = 1750;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000000;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
        logic                   func;
        logic [BYTE_W-1:0]      data;
        logic                   typed;
        logic [BYTE_W-1:0]      exp_byte;
        logic                   exp_nk;
    } t_stim_row;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic              not_keyed;
    } t_cipher_res;

    logic                 i_clk;
    logic                 i_rst_n   = 1'b0;
    logic                 req_valid = 1'b0;
    logic [BYTE_W-1:0]    req_byte  = '0;
    logic                 req_func  = FUNC_KEY;
    logic                 res_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DROP_BLOCKS;
    logic [CFG_W-1:0]     cfg_val   = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [BYTE_W-1:0]    o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    // keystream predictor state
    logic [7:0]   rc4_perm [STATE_SIZE];
    logic [7:0]   rc4_key  [STATE_SIZE];
    logic [7:0]   rc4_i, rc4_j;
    logic [8:0]   rc4_count;
    logic         rc4_keyed;
    logic [7:0]   rc4_drop;
    logic [8:0]   rc4_klen;

    t_cipher_res  cipher_out_q [$];
    t_stim_row    stim_rows [$];
    int           err_count     = 0;
    int           items_sent    = 0;
    int           res_hold_left = 0;
    bit           src_idle_en   = 1'b1;
    bit           res_idle_en   = 1'b1;

    rc4_drop_stream_cipher_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (req_byte),
        .i_s_axis_tuser  (req_func),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_idx),
        .i_cfg_wdata     (cfg_val)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic void rc4_swap();
        logic [7:0] t;
        t              = rc4_perm[rc4_i];
        rc4_perm[rc4_i] = rc4_perm[rc4_j];
        rc4_perm[rc4_j] = t;
    endfunction

    function automatic logic [7:0] rc4_next();
        logic [7:0] sum;
        rc4_i = rc4_i + 8'd1;
        rc4_j = rc4_j + rc4_perm[rc4_i];
        rc4_swap();
        sum = rc4_perm[rc4_i] + rc4_perm[rc4_j];
        return rc4_perm[sum];
    endfunction

    // key schedule over the stored key, then the keystream drop
    function automatic void rc4_schedule(input int unsigned len);
        int unsigned k;
        k = 0;
        for (int n = 0; n < STATE_SIZE; n++) rc4_perm[n] = 8'(n);
        rc4_j = '0;
        for (int n = 0; n < STATE_SIZE; n++) begin
            rc4_i = 8'(n);
            rc4_j = rc4_j + rc4_perm[rc4_i] + rc4_key[k];
            rc4_swap();
            k = (k + 1 >= len) ? 0 : k + 1;
        end
        rc4_i = '0;
        rc4_j = '0;
        for (int d = 0; d < int'(rc4_drop) * 256; d++) void'(rc4_next());
    endfunction

    // advance on one accepted request; returns 1 when a result is due
    function automatic bit rc4_advance(input logic f, input logic [7:0] b,
                                       output t_cipher_res r);
        int unsigned len;
        len = (rc4_klen == 0 || rc4_klen > KLEN_MAX) ? STATE_SIZE : rc4_klen;
        r   = '0;
        if (f == FUNC_KEY) begin
            if (rc4_keyed) begin
                rc4_keyed = 1'b0;
                rc4_count = '0;
            end
            rc4_key[rc4_count[7:0]] = b;
            if (rc4_count < STATE_SIZE) rc4_count++;
            if (rc4_count >= len) begin
                rc4_schedule(len);
                rc4_keyed = 1'b1;
                rc4_count = '0;
            end
            return 1'b0;
        end
        if (rc4_keyed) begin
            r.byte_out  = b ^ rc4_next();
            r.not_keyed = 1'b0;
        end else begin
            r.byte_out  = b;
            r.not_keyed = 1'b1;
        end
        return 1'b1;
    endfunction

    // ---------------- table builders ----------------

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        t_stim_row row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_req(input logic f, input logic [7:0] b);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_REQ;
        row.func = f;
        row.data = b;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_req_chk(input logic f, input logic [7:0] b,
                                        input logic [7:0] eb, input logic nk);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_REQ;
        row.func     = f;
        row.data     = b;
        row.typed    = 1'b1;
        row.exp_byte = eb;
        row.exp_nk   = nk;
        stim_rows.push_back(row);
    endfunction

    // ---------------- drivers ----------------

    // offer one request, with random gaps, and predict it once accepted
    task automatic send_req(input logic f, input logic [7:0] b, input logic typed,
                            input logic [7:0] eb, input logic enk);
        t_cipher_res r;
        bit          due;
        while (src_idle_en && $urandom_range(0, 99) < 7) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_byte  <= b;
        req_func  <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        due = rc4_advance(f, b, r);
        if (due) cipher_out_q.push_back(typed ? t_cipher_res'({eb, enk}) : r);
    endtask

    task automatic send_data_rand();
        send_req(FUNC_DATA, 8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
    endtask

    task automatic send_key_rand();
        send_req(FUNC_KEY, 8'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
    endtask

    // drain results, let a key schedule finish, then the block is idle
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (cipher_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we  <= 1'b1;
        cfg_idx <= idx;
        cfg_val <= val;
        @(posedge i_clk);
        if (idx == CFG_DROP_BLOCKS) rc4_drop = val[DROP_W-1:0];
        else rc4_klen = val[KLEN_W-1:0];
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- result side ----------------

    // ready with random stalls, or a counted hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (res_hold_left > 0) begin
                res_ready <= 1'b0;
                res_hold_left--;
            end else begin
                res_ready <= !(res_idle_en && $urandom_range(0, 99) < 7);
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_cipher_res want;
        if (i_rst_n && o_m_axis_tvalid && res_ready) begin
            if (cipher_out_q.size() == 0) begin
                $error("unexpected result: byte_out %02h not_keyed %0b",
                       o_m_axis_tdata, o_m_axis_tuser);
                err_count++;
            end else begin
                want = cipher_out_q.pop_front();
                if (o_m_axis_tdata !== want.byte_out) begin
                    $error("byte_out: expected %02h, got %02h", want.byte_out, o_m_axis_tdata);
                    err_count++;
                end
                if (o_m_axis_tuser !== want.not_keyed) begin
                    $error("not_keyed: expected %0b, got %0b", want.not_keyed, o_m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // no request moving on either side for too long
    always @(posedge i_clk) begin
        int stuck_cycles;
        if (!i_rst_n || (req_valid && o_s_axis_tready) || (o_m_axis_tvalid && res_ready) || cfg_we)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("rc4_drop_stream_cipher_core test failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        t_stim_row  row;
        int         phase;
        int         n;
        int         split;
        int         ev;
        int         nd;
        bit         abandon;
        logic [8:0] klen_pick;

        // predictor after reset
        for (int k = 0; k < STATE_SIZE; k++) begin
            rc4_perm[k] = 8'(k);
            rc4_key[k]  = '0;
        end
        rc4_i     = '0;
        rc4_j     = '0;
        rc4_count = '0;
        rc4_keyed = 1'b0;
        rc4_drop  = '0;
        rc4_klen  = 9'd16;

        // data before any key passes through
        add_req_chk(FUNC_DATA, 8'h00, 8'h00, 1'b1);
        add_req_chk(FUNC_DATA, 8'hFF, 8'hFF, 1'b1);
        // classic three-byte key "Key" on "Plain", no drop
        add_cfg(CFG_KEY_LENGTH, 9'd3);
        add_req(FUNC_KEY, 8'h4B);
        add_req(FUNC_KEY, 8'h65);
        add_req(FUNC_KEY, 8'h79);
        add_req_chk(FUNC_DATA, 8'h50, 8'hBB, 1'b0);
        add_req_chk(FUNC_DATA, 8'h6C, 8'hF3, 1'b0);
        add_req_chk(FUNC_DATA, 8'h61, 8'h16, 1'b0);
        add_req_chk(FUNC_DATA, 8'h69, 8'hE8, 1'b0);
        add_req_chk(FUNC_DATA, 8'h6E, 8'hD9, 1'b0);
        // key byte while keyed opens a new load; data in between is unkeyed
        add_req(FUNC_KEY, 8'h00);
        add_req_chk(FUNC_DATA, 8'hA5, 8'hA5, 1'b1);
        add_req(FUNC_KEY, 8'hFF);
        // shorter key length mid-load: next key byte completes it
        add_cfg(CFG_KEY_LENGTH, 9'd1);
        add_req(FUNC_KEY, 8'h80);
        add_req(FUNC_DATA, 8'h00);
        add_req(FUNC_DATA, 8'hFF);
        // deepest drop with a one-byte key
        add_cfg(CFG_DROP_BLOCKS, 9'd255);
        add_req(FUNC_KEY, 8'hFF);
        add_req(FUNC_DATA, 8'h3C);
        // register writes while keyed wait for the next load
        add_cfg(CFG_DROP_BLOCKS, 9'd1);
        add_cfg(CFG_KEY_LENGTH, 9'd2);
        add_req(FUNC_DATA, 8'h77);
        add_req(FUNC_KEY, 8'h01);
        add_req(FUNC_KEY, 8'hFE);
        add_req(FUNC_DATA, 8'h5A);
        add_cfg(CFG_DROP_BLOCKS, 9'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_req(row.func, row.data, row.typed, row.exp_byte, row.exp_nk);
            end
        end

        // random phases: config, key load, data burst
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            src_idle_en = !(phase >= 8 && phase < 14);
            res_idle_en = src_idle_en;

            ev = $urandom_range(0, 99);
            if (phase == 0) klen_pick = '0;
            else if (phase == 1) klen_pick = 9'($urandom_range(257, 511));
            else if (phase == 2) klen_pick = KLEN_MAX;
            else if (ev < 60) klen_pick = 9'($urandom_range(1, 16));
            else if (ev < 85) klen_pick = 9'($urandom_range(17, 64));
            else if (ev < 97) klen_pick = 9'($urandom_range(65, 255));
            else klen_pick = KLEN_MAX;
            write_reg(CFG_KEY_LENGTH, klen_pick);
            if (phase < 3 || $urandom_range(0, 99) < 60)
                write_reg(CFG_DROP_BLOCKS, ($urandom_range(0, 99) < 80) ?
                          9'($urandom_range(0, 1)) : 9'($urandom_range(2, 3)));

            // stray data ahead of the load
            if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 4)) send_data_rand();

            // key load, sometimes interrupted
            n       = 0;
            split   = $urandom_range(1, 24);
            ev      = $urandom_range(0, 99);
            abandon = 1'b0;
            do begin
                send_key_rand();
                n++;
                if (n == split && !rc4_keyed) begin
                    if (ev < 10) begin
                        abandon = 1'b1;
                    end else if (ev < 20) begin
                        repeat ($urandom_range(1, 3)) send_data_rand();
                    end else if (ev < 30) begin
                        wait_idle();
                        write_reg(CFG_KEY_LENGTH, 9'($urandom_range(1, 24)));
                    end
                end
            end while (!rc4_keyed && !abandon);

            // data burst; one phase holds the result side off to back up the block
            nd = $urandom_range(4, 48);
            if (phase == 3) begin
                res_hold_left = 400;
                nd = 64;
            end
            repeat (nd) begin
                if ($urandom_range(0, 99) < 3) send_key_rand();
                else send_data_rand();
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && cipher_out_q.size() == 0) begin
            $display("rc4_drop_stream_cipher_core test passed");
        end else begin
            $display("rc4_drop_stream_cipher_core test failed");
        end
        $finish;
    end

endmodule
